### src/lfpc_pkg.sv
// Package for the LED fade and pulse controller: word types, opcodes,
// register indexes and per-LED control structs. No dependencies.
package lfpc_pkg;

	// Number of LED channels and the fixed constants of the fade logic
	localparam int LED_CNT = 2;
	localparam logic [7:0] PULSE_ENDLESS = 8'hFF;
	localparam logic [7:0] ON_THRESHOLD = 8'd5;

	// Input word opcodes (code 3 is unused and changes nothing)
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_SET   = 2'd1,
		OP_PULSE = 2'd2
	} op_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LEFT_FADE_DELAY  = 3'd0,
		REG_LEFT_FADE_STEP   = 3'd1,
		REG_RIGHT_FADE_DELAY = 3'd2,
		REG_RIGHT_FADE_STEP  = 3'd3,
		REG_LEFT_PULSE_HIGH  = 3'd4,
		REG_LEFT_PULSE_LOW   = 3'd5,
		REG_RIGHT_PULSE_HIGH = 3'd6,
		REG_RIGHT_PULSE_LOW  = 3'd7
	} reg_idx_t;

	// Input word
	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] led_select;
		logic       eye_mask;
		logic [7:0] target_level;
		logic [7:0] pulse_total;
		logic [7:0] pulse_gap;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [7:0] left_level;
		logic [7:0] right_level;
		logic       left_on;
		logic       right_on;
		logic       changed;
		logic       left_fading;
		logic       left_pulsing;
		logic       right_fading;
		logic       right_pulsing;
	} out_word_t;

	// Per-LED configuration
	typedef struct packed {
		logic [7:0] delay;
		logic [7:0] step;
		logic [7:0] high;
		logic [7:0] low;
	} led_cfg_t;

	// Per-LED command decoded from an accepted input word
	typedef struct packed {
		logic       en;
		logic       tick;
		logic       set;
		logic       pulse;
		logic [7:0] target;
		logic [7:0] total;
		logic [7:0] gap;
	} led_cmd_t;

	// Per-LED status after the word has been applied
	typedef struct packed {
		logic [7:0] level;
		logic       fading;
		logic       pulsing;
		logic       stepped;
	} led_stat_t;

endpackage

### src/led_fade_pulse_controller_top.sv
// Top level of the two-LED fade and pulse controller.
// Depends on lfpc_pkg and lfpc_led.
//
// Usage:
//   in_valid/in_ready/in_data carry one word: a tick (with the eye mask),
//   a set-intensity command or a pulse command. out_valid/out_ready/out_data
//   return exactly one result word per input word, in order.
//   cfg_we/cfg_index/cfg_data write one of the eight 8-bit fade and pulse
//   registers; write only while the block is idle.
// Timing:
//   the result appears in the cycle after its word is accepted. One word
//   per cycle is sustained while out_ready is high; each word is a single
//   pass of compare and add logic per LED between state and result registers.
// Stall:
//   the result register holds while out_ready is low; in_ready then drops
//   until the result is taken, and is high again in the cycle it is taken.
// Reset:
//   arst_n clears all LED state, the mask and the result valid flag and loads
//   the register defaults (delay 1, step 2, pulse high 255, pulse low 0).
module led_fade_pulse_controller_top import lfpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] cfg_q [8];
	logic       mask_q;
	logic       out_valid_q;
	out_word_t  out_data_q;
	logic       accept, is_tick, mask_n, changed;
	led_cfg_t   led_cfg  [LED_CNT];
	led_cmd_t   led_cmd  [LED_CNT];
	led_stat_t  led_stat [LED_CNT];

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign is_tick  = (in_data.opcode == OP_TICK);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_LEFT_FADE_DELAY]  <= 8'd1;
			cfg_q[REG_LEFT_FADE_STEP]   <= 8'd2;
			cfg_q[REG_RIGHT_FADE_DELAY] <= 8'd1;
			cfg_q[REG_RIGHT_FADE_STEP]  <= 8'd2;
			cfg_q[REG_LEFT_PULSE_HIGH]  <= 8'hFF;
			cfg_q[REG_LEFT_PULSE_LOW]   <= 8'd0;
			cfg_q[REG_RIGHT_PULSE_HIGH] <= 8'hFF;
			cfg_q[REG_RIGHT_PULSE_LOW]  <= 8'd0;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign led_cfg[0] = '{delay: cfg_q[REG_LEFT_FADE_DELAY], step: cfg_q[REG_LEFT_FADE_STEP],
		high: cfg_q[REG_LEFT_PULSE_HIGH], low: cfg_q[REG_LEFT_PULSE_LOW]};
	assign led_cfg[1] = '{delay: cfg_q[REG_RIGHT_FADE_DELAY], step: cfg_q[REG_RIGHT_FADE_STEP],
		high: cfg_q[REG_RIGHT_PULSE_HIGH], low: cfg_q[REG_RIGHT_PULSE_LOW]};

	// Per-LED channels
	for (genvar i = 0; i < LED_CNT; i++) begin : g_led
		assign led_cmd[i].en     = accept;
		assign led_cmd[i].tick   = is_tick;
		assign led_cmd[i].set    = (in_data.opcode == OP_SET) && in_data.led_select[i];
		assign led_cmd[i].pulse  = (in_data.opcode == OP_PULSE) && in_data.led_select[i];
		assign led_cmd[i].target = in_data.target_level;
		assign led_cmd[i].total  = in_data.pulse_total;
		assign led_cmd[i].gap    = in_data.pulse_gap;

		lfpc_led u_led (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (led_cmd[i]),
			.cfg    (led_cfg[i]),
			.stat   (led_stat[i])
		);
	end

	// Eye mask is latched on ticks only
	assign mask_n  = is_tick ? in_data.eye_mask : mask_q;
	assign changed = is_tick &&
		(led_stat[0].stepped || led_stat[1].stepped || (in_data.eye_mask != mask_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 1'b0;
		end else if (accept) begin
			mask_q <= mask_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.left_level    <= led_stat[0].level;
			out_data_q.right_level   <= led_stat[1].level;
			out_data_q.left_on       <= (led_stat[0].level > ON_THRESHOLD) && !mask_n;
			out_data_q.right_on      <= (led_stat[1].level > ON_THRESHOLD) && !mask_n;
			out_data_q.changed       <= changed;
			out_data_q.left_fading   <= led_stat[0].fading;
			out_data_q.left_pulsing  <= led_stat[0].pulsing;
			out_data_q.right_fading  <= led_stat[1].fading;
			out_data_q.right_pulsing <= led_stat[1].pulsing;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A command word never reports a change
	a_cmd_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.opcode != OP_TICK) |=> !out_data.changed)
		else $error("command word reported changed");

	// Left on flag only above the dark threshold
	a_on_level: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.left_on) |-> (out_data.left_level > ON_THRESHOLD))
		else $error("left LED on at or below threshold");

	// Set intensity on the left LED starts a fade and stops pulsing
	a_set_fades: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.opcode == OP_SET && in_data.led_select[0])
		|=> (out_data.left_fading && !out_data.left_pulsing))
		else $error("set intensity did not start left fade");

endmodule

### src/lfpc_led.sv
// One LED channel of the fade and pulse controller: state registers and
// the single-pass update for one word. Depends on lfpc_pkg.
module lfpc_led import lfpc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  led_cmd_t  cmd,
	input  led_cfg_t  cfg,
	output led_stat_t stat
);

	logic [7:0] level_q, setp_q, wait_q, gap_q, left_q, gaplen_q;
	logic       fade_q, pulse_q, due_q;
	logic [7:0] level_n, setp_n, wait_n, gap_n, left_n, gaplen_n;
	logic       fade_n, pulse_n, due_n, stepped, more;
	logic [8:0] rise_sum;

	assign rise_sum = {1'b0, level_q} + {1'b0, cfg.step};

	// Next state for one word
	always_comb begin
		level_n  = level_q;
		setp_n   = setp_q;
		wait_n   = wait_q;
		gap_n    = gap_q;
		left_n   = left_q;
		gaplen_n = gaplen_q;
		fade_n   = fade_q;
		pulse_n  = pulse_q;
		due_n    = due_q;
		stepped  = 1'b0;
		more     = 1'b0;
		if (cmd.tick) begin
			// fade step, landing exactly on the setpoint
			if (fade_q) begin
				if (wait_q == 8'd0) begin
					stepped = 1'b1;
					if (setp_q > level_q) begin
						if (rise_sum >= {1'b0, setp_q}) begin
							level_n = setp_q;
							fade_n  = 1'b0;
						end else begin
							level_n = rise_sum[7:0];
							wait_n  = cfg.delay - 8'd1;
						end
					end else begin
						if (level_q < cfg.step || (level_q - cfg.step) <= setp_q) begin
							level_n = setp_q;
							fade_n  = 1'b0;
						end else begin
							level_n = level_q - cfg.step;
							wait_n  = cfg.delay - 8'd1;
						end
					end
				end else begin
					wait_n = wait_q - 8'd1;
				end
			end
			// gap timer between pulses
			if (gap_q != 8'd0) begin
				gap_n = gap_q - 8'd1;
				if (gap_q == 8'd1) begin
					due_n = 1'b1;
				end
			end
			// start the next pulse fade once the current fade is done
			if (!fade_n && due_n) begin
				if (left_q == PULSE_ENDLESS) begin
					more = 1'b1;
				end else begin
					left_n = left_q - 8'd1;
					more   = (left_q != 8'd1);
				end
				if (more) begin
					gap_n = gaplen_q;
				end else begin
					pulse_n = 1'b0;
				end
				setp_n = (level_n <= cfg.low) ? cfg.high : cfg.low;
				fade_n = 1'b1;
				wait_n = cfg.delay;
				due_n  = 1'b0;
			end
		end else if (cmd.set) begin
			setp_n  = cmd.target;
			fade_n  = 1'b1;
			pulse_n = 1'b0;
			gap_n   = 8'd0;
			due_n   = 1'b0;
		end else if (cmd.pulse) begin
			pulse_n  = 1'b1;
			gaplen_n = cmd.gap;
			if (cmd.total != 8'd0) begin
				left_n = cmd.total;
				if (gap_q == 8'd0) begin
					due_n = 1'b1;
				end
			end
		end
	end

	// State registers, updated on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			setp_q   <= '0;
			wait_q   <= '0;
			gap_q    <= '0;
			left_q   <= '0;
			gaplen_q <= '0;
			fade_q   <= 1'b0;
			pulse_q  <= 1'b0;
			due_q    <= 1'b0;
		end else if (cmd.en) begin
			level_q  <= level_n;
			setp_q   <= setp_n;
			wait_q   <= wait_n;
			gap_q    <= gap_n;
			left_q   <= left_n;
			gaplen_q <= gaplen_n;
			fade_q   <= fade_n;
			pulse_q  <= pulse_n;
			due_q    <= due_n;
		end
	end

	assign stat.level   = level_n;
	assign stat.fading  = fade_n;
	assign stat.pulsing = pulse_n;
	assign stat.stepped = stepped;

endmodule
